### design/nfs_pkg.sv
// ----------------------------------------------------------------------------
// nfs_pkg
// Shared sizes, state codes and compare helpers for the non-preemptive
// FCFS / SJF job scheduler.
// ----------------------------------------------------------------------------
package nfs_pkg;

	localparam int MAX_JOBS  = 64;
	localparam int TIME_BITS = 16;
	localparam int IDX_W     = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
	localparam int CNT_W     = $clog2(MAX_JOBS + 1);
	localparam int CLK_W     = 23;
	localparam int FRAC_W    = 8;
	localparam int WT_W      = CLK_W + FRAC_W;
	localparam int CMP_W     = (CLK_W > TIME_BITS) ? CLK_W : TIME_BITS;
	localparam int DIVC_W    = $clog2(WT_W + 1);
	localparam int JIDX_W    = 6;

	localparam logic POLICY_FCFS = 1'b0;
	localparam logic POLICY_SJF  = 1'b1;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_SCAN,
		ST_CALC,
		ST_DIV,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic             clr;
		logic             vld;
		logic [IDX_W-1:0] idx;
		logic             done;
		logic             policy;
		logic [CLK_W-1:0] now;
	} scan_ctl_t;

	// arrival first, then run time; equal keys keep the earlier index
	function automatic logic fcfs_before(
		input logic [TIME_BITS-1:0] a_arr,
		input logic [TIME_BITS-1:0] a_run,
		input logic [TIME_BITS-1:0] b_arr,
		input logic [TIME_BITS-1:0] b_run
	);
		logic res;
		if (a_arr != b_arr) begin
			res = (a_arr < b_arr);
		end else begin
			res = (a_run < b_run);
		end
		return res;
	endfunction

endpackage

### design/nfs_store.sv
// ----------------------------------------------------------------------------
// nfs_store
// Job memory: arrival and run time per load slot, one write and one
// registered read per cycle.
// ----------------------------------------------------------------------------
module nfs_store (
	input  logic                            clk,
	input  logic                            we,
	input  logic [nfs_pkg::IDX_W-1:0]       waddr,
	input  logic [nfs_pkg::TIME_BITS-1:0]   warr,
	input  logic [nfs_pkg::TIME_BITS-1:0]   wrun,
	input  logic                            re,
	input  logic [nfs_pkg::IDX_W-1:0]       raddr,
	output logic [nfs_pkg::TIME_BITS-1:0]   rarr,
	output logic [nfs_pkg::TIME_BITS-1:0]   rrun
);

	logic [2*nfs_pkg::TIME_BITS-1:0] mem_q [nfs_pkg::MAX_JOBS];
	logic [2*nfs_pkg::TIME_BITS-1:0] rd_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= {warr, wrun};
		end
		if (re) begin
			rd_q <= mem_q[raddr];
		end
	end

	assign rarr = rd_q[2*nfs_pkg::TIME_BITS-1:nfs_pkg::TIME_BITS];
	assign rrun = rd_q[nfs_pkg::TIME_BITS-1:0];

endmodule

### design/nfs_pick.sv
// ----------------------------------------------------------------------------
// nfs_pick
// Running best-job search: one stored job per cycle is compared against the
// best arrived job under the policy and the best pending job by arrival.
// ----------------------------------------------------------------------------
module nfs_pick (
	input  logic                            clk,
	input  logic                            arst_n,
	input  nfs_pkg::scan_ctl_t              ctl,
	input  logic [nfs_pkg::TIME_BITS-1:0]   arr,
	input  logic [nfs_pkg::TIME_BITS-1:0]   run,
	output logic [nfs_pkg::IDX_W-1:0]       sel_idx,
	output logic [nfs_pkg::TIME_BITS-1:0]   sel_arr,
	output logic [nfs_pkg::TIME_BITS-1:0]   sel_run
);

	logic                          ra_found_q;
	logic                          any_found_q;
	logic [nfs_pkg::IDX_W-1:0]     ra_idx_q;
	logic [nfs_pkg::TIME_BITS-1:0] ra_arr_q;
	logic [nfs_pkg::TIME_BITS-1:0] ra_run_q;
	logic [nfs_pkg::IDX_W-1:0]     any_idx_q;
	logic [nfs_pkg::TIME_BITS-1:0] any_arr_q;
	logic [nfs_pkg::TIME_BITS-1:0] any_run_q;
	logic                          arrived;
	logic                          ra_better;
	logic                          any_better;
	logic                          ra_take;
	logic                          any_take;

	always_comb begin
		arrived = (nfs_pkg::CMP_W'(arr) <= nfs_pkg::CMP_W'(ctl.now));
		if (ctl.policy == nfs_pkg::POLICY_SJF) begin
			ra_better = (run < ra_run_q);
		end else begin
			ra_better = nfs_pkg::fcfs_before(arr, run, ra_arr_q, ra_run_q);
		end
		any_better = nfs_pkg::fcfs_before(arr, run, any_arr_q, any_run_q);
		ra_take  = ctl.vld && !ctl.done && arrived && (!ra_found_q || ra_better);
		any_take = ctl.vld && !ctl.done && (!any_found_q || any_better);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ra_found_q  <= 1'b0;
			any_found_q <= 1'b0;
		end else if (ctl.clr) begin
			ra_found_q  <= 1'b0;
			any_found_q <= 1'b0;
		end else begin
			if (ra_take) begin
				ra_found_q <= 1'b1;
			end
			if (any_take) begin
				any_found_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ra_take) begin
			ra_idx_q <= ctl.idx;
			ra_arr_q <= arr;
			ra_run_q <= run;
		end
		if (any_take) begin
			any_idx_q <= ctl.idx;
			any_arr_q <= arr;
			any_run_q <= run;
		end
	end

	assign sel_idx = ra_found_q ? ra_idx_q : any_idx_q;
	assign sel_arr = ra_found_q ? ra_arr_q : any_arr_q;
	assign sel_run = ra_found_q ? ra_run_q : any_run_q;

endmodule

### design/nfs_div.sv
// ----------------------------------------------------------------------------
// nfs_div
// Restoring divider, one quotient bit per cycle. A zero divisor yields an
// all-ones quotient.
// ----------------------------------------------------------------------------
module nfs_div (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            go,
	input  logic [nfs_pkg::WT_W-1:0]        dividend,
	input  logic [nfs_pkg::TIME_BITS-1:0]   divisor,
	output logic                            done,
	output logic [nfs_pkg::WT_W-1:0]        quotient
);

	logic                          busy_q;
	logic [nfs_pkg::DIVC_W-1:0]    cnt_q;
	logic [nfs_pkg::WT_W-1:0]      dq_q;
	logic [nfs_pkg::TIME_BITS-1:0] rem_q;
	logic [nfs_pkg::TIME_BITS-1:0] dvs_q;
	logic [nfs_pkg::TIME_BITS:0]   trial;
	logic                          qbit;
	logic [nfs_pkg::TIME_BITS:0]   diff;

	always_comb begin
		trial = {rem_q, dq_q[nfs_pkg::WT_W-1]};
		qbit  = (trial >= {1'b0, dvs_q});
		diff  = trial - {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (go) begin
			busy_q <= 1'b1;
			cnt_q  <= nfs_pkg::DIVC_W'(nfs_pkg::WT_W);
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			dq_q  <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q && cnt_q != '0) begin
			dq_q  <= {dq_q[nfs_pkg::WT_W-2:0], qbit};
			rem_q <= qbit ? diff[nfs_pkg::TIME_BITS-1:0] : trial[nfs_pkg::TIME_BITS-1:0];
		end
	end

	assign done     = busy_q && (cnt_q == '0);
	assign quotient = dq_q;

endmodule

### design/nonpreemptive_fcfs_sjf_scheduler.sv
// ----------------------------------------------------------------------------
// nonpreemptive_fcfs_sjf_scheduler
// Loads jobs until the last one, then runs a non-preemptive FCFS or SJF
// schedule and emits one item per job in run order.
//
//   channel  handshake              payload
//   cfg      cfg_valid / cfg_ready  policy
//   in       in_valid / in_ready    arrival_time, run_time, last_job
//   out      out_valid / out_ready  job_index, start_time, finish_time,
//                                   turnaround, weighted_turnaround,
//                                   last_result
//
// Loading stores each input item in the job memory. Each result of a set
// of n jobs needs a memory scan (one stored job per cycle through the
// single read port), a step of time arithmetic, the bit-serial divider and
// an output step that holds while out_ready is low.
// Reset clears the job count, done marks, clock and policy; the job memory
// is not cleared. The input stays not ready while a set is scheduled.
// ----------------------------------------------------------------------------
module nonpreemptive_fcfs_sjf_scheduler (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic                                policy,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [15:0]                         arrival_time,
	input  logic [15:0]                         run_time,
	input  logic                                last_job,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [nfs_pkg::JIDX_W-1:0]          job_index,
	output logic [nfs_pkg::CLK_W-1:0]           start_time,
	output logic [nfs_pkg::CLK_W-1:0]           finish_time,
	output logic [nfs_pkg::CLK_W-1:0]           turnaround,
	output logic [nfs_pkg::WT_W-1:0]            weighted_turnaround,
	output logic                                last_result
);

	nfs_pkg::state_t               state_q;
	nfs_pkg::state_t               state_d;
	logic                          policy_q;
	logic [nfs_pkg::CNT_W-1:0]     count_q;
	logic [nfs_pkg::CNT_W-1:0]     issue_q;
	logic [nfs_pkg::CNT_W-1:0]     k_q;
	logic [nfs_pkg::CLK_W-1:0]     cur_q;
	logic [nfs_pkg::MAX_JOBS-1:0]  done_q;
	logic                          vld_s1;
	logic [nfs_pkg::IDX_W-1:0]     idx_s1;
	logic [nfs_pkg::IDX_W-1:0]     jidx_q;
	logic [nfs_pkg::CLK_W-1:0]     start_q;
	logic [nfs_pkg::CLK_W-1:0]     fin_q;
	logic [nfs_pkg::CLK_W-1:0]     tat_q;

	logic                          in_acc;
	logic                          out_acc;
	logic                          is_last;
	logic                          room;
	logic                          scan_issue;
	logic                          scan_end;
	logic                          div_go;
	logic                          div_done;
	logic [nfs_pkg::WT_W-1:0]      div_q;
	logic [nfs_pkg::TIME_BITS-1:0] arr_in;
	logic [nfs_pkg::TIME_BITS-1:0] run_in;
	logic [nfs_pkg::TIME_BITS-1:0] rd_arr;
	logic [nfs_pkg::TIME_BITS-1:0] rd_run;
	logic [nfs_pkg::IDX_W-1:0]     sel_idx;
	logic [nfs_pkg::TIME_BITS-1:0] sel_arr;
	logic [nfs_pkg::TIME_BITS-1:0] sel_run;
	logic [nfs_pkg::CMP_W-1:0]     start_w;
	logic [nfs_pkg::CLK_W-1:0]     start_c;
	logic [nfs_pkg::CLK_W-1:0]     fin_c;
	logic [nfs_pkg::CLK_W-1:0]     tat_c;
	nfs_pkg::scan_ctl_t            ctl;

	assign arr_in  = nfs_pkg::TIME_BITS'(arrival_time);
	assign run_in  = nfs_pkg::TIME_BITS'(run_time);
	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;
	assign room    = (count_q < nfs_pkg::CNT_W'(nfs_pkg::MAX_JOBS));
	assign is_last = (nfs_pkg::CNT_W'(k_q + 1'b1) == count_q);
	assign scan_issue = (state_q == nfs_pkg::ST_SCAN) && (issue_q < count_q);
	assign scan_end   = (issue_q == count_q) && !vld_s1;

	always_comb begin
		state_d = state_q;
		case (state_q)
			nfs_pkg::ST_LOAD: begin
				if (in_valid && last_job) begin
					state_d = nfs_pkg::ST_SCAN;
				end
			end
			nfs_pkg::ST_SCAN: begin
				if (scan_end) begin
					state_d = nfs_pkg::ST_CALC;
				end
			end
			nfs_pkg::ST_CALC: begin
				state_d = nfs_pkg::ST_DIV;
			end
			nfs_pkg::ST_DIV: begin
				if (div_done) begin
					state_d = nfs_pkg::ST_OUT;
				end
			end
			nfs_pkg::ST_OUT: begin
				if (out_ready) begin
					state_d = is_last ? nfs_pkg::ST_LOAD : nfs_pkg::ST_SCAN;
				end
			end
			default: begin
				state_d = nfs_pkg::ST_LOAD;
			end
		endcase
	end

	always_comb begin
		in_ready  = 1'b0;
		out_valid = 1'b0;
		div_go    = 1'b0;
		case (state_q)
			nfs_pkg::ST_LOAD: in_ready  = 1'b1;
			nfs_pkg::ST_CALC: div_go    = 1'b1;
			nfs_pkg::ST_OUT:  out_valid = 1'b1;
			default: begin
				in_ready  = 1'b0;
				out_valid = 1'b0;
				div_go    = 1'b0;
			end
		endcase
	end

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= nfs_pkg::ST_LOAD;
			policy_q <= nfs_pkg::POLICY_FCFS;
			count_q  <= '0;
			issue_q  <= '0;
			k_q      <= '0;
			cur_q    <= '0;
			done_q   <= '0;
			vld_s1   <= 1'b0;
		end else begin
			state_q <= state_d;
			vld_s1  <= scan_issue;
			if (cfg_valid && cfg_ready) begin
				policy_q <= policy;
			end
			if (in_acc && room) begin
				count_q <= count_q + 1'b1;
				done_q[count_q[nfs_pkg::IDX_W-1:0]] <= 1'b0;
			end
			if (state_q == nfs_pkg::ST_LOAD || state_q == nfs_pkg::ST_OUT) begin
				issue_q <= '0;
			end else if (scan_issue) begin
				issue_q <= issue_q + 1'b1;
			end
			if (out_acc) begin
				if (is_last) begin
					count_q <= '0;
					k_q     <= '0;
					cur_q   <= '0;
					done_q  <= '0;
				end else begin
					k_q    <= k_q + 1'b1;
					cur_q  <= fin_q;
					done_q[jidx_q] <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (scan_issue) begin
			idx_s1 <= issue_q[nfs_pkg::IDX_W-1:0];
		end
		if (state_q == nfs_pkg::ST_CALC) begin
			jidx_q  <= sel_idx;
			start_q <= start_c;
			fin_q   <= fin_c;
			tat_q   <= tat_c;
		end
	end

	always_comb begin
		if (nfs_pkg::CMP_W'(cur_q) > nfs_pkg::CMP_W'(sel_arr)) begin
			start_w = nfs_pkg::CMP_W'(cur_q);
		end else begin
			start_w = nfs_pkg::CMP_W'(sel_arr);
		end
		start_c = nfs_pkg::CLK_W'(start_w);
		fin_c   = start_c + nfs_pkg::CLK_W'(sel_run);
		tat_c   = fin_c - nfs_pkg::CLK_W'(sel_arr);
	end

	always_comb begin
		ctl.clr    = (state_q == nfs_pkg::ST_SCAN) && (issue_q == '0);
		ctl.vld    = vld_s1;
		ctl.idx    = idx_s1;
		ctl.done   = done_q[idx_s1];
		ctl.policy = policy_q;
		ctl.now    = cur_q;
	end

	nfs_store u_store (
		.clk   (clk),
		.we    (in_acc && room),
		.waddr (count_q[nfs_pkg::IDX_W-1:0]),
		.warr  (arr_in),
		.wrun  (run_in),
		.re    (scan_issue),
		.raddr (issue_q[nfs_pkg::IDX_W-1:0]),
		.rarr  (rd_arr),
		.rrun  (rd_run)
	);

	nfs_pick u_pick (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ctl),
		.arr     (rd_arr),
		.run     (rd_run),
		.sel_idx (sel_idx),
		.sel_arr (sel_arr),
		.sel_run (sel_run)
	);

	nfs_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (div_go),
		.dividend ({tat_c, {nfs_pkg::FRAC_W{1'b0}}}),
		.divisor  (sel_run),
		.done     (div_done),
		.quotient (div_q)
	);

	assign job_index           = nfs_pkg::JIDX_W'(jidx_q);
	assign start_time          = start_q;
	assign finish_time         = fin_q;
	assign turnaround          = tat_q;
	assign weighted_turnaround = div_q;
	assign last_result         = is_last;

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input ready while a result is pending");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= nfs_pkg::CNT_W'(nfs_pkg::MAX_JOBS))
		else $error("job count beyond store depth");

	a_set_end: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && last_result) |=> (in_ready && count_q == '0))
		else $error("block not reloaded after final result");

	a_div_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == nfs_pkg::ST_DIV))
		else $error("divider finished outside its step");

	a_scan_set: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == nfs_pkg::ST_SCAN) |-> (count_q != '0))
		else $error("scan started on an empty set");

endmodule
